FILE: rtl/rxrft_pkg.sv
// Shared constants and result type for the receive ring frame tracker.
`default_nettype none

package rxrft_pkg;

  // Header status error flags: bad symbol, runt, too long, CRC, alignment.
  localparam logic [15:0] ERR_SYMBOL  = 16'h0020;
  localparam logic [15:0] ERR_RUNT    = 16'h0010;
  localparam logic [15:0] ERR_LONG    = 16'h0008;
  localparam logic [15:0] ERR_CRC     = 16'h0004;
  localparam logic [15:0] ERR_ALIGN   = 16'h0002;
  localparam logic [15:0] ERR_FLAGS   = ERR_SYMBOL | ERR_RUNT | ERR_LONG | ERR_CRC | ERR_ALIGN;

  // Frame check sequence length in bytes.
  localparam logic [15:0] FCS_BYTES   = 16'd4;

  // Mask that clears the low two bits for dword alignment.
  localparam logic [15:0] DWORD_MASK  = 16'hFFFC;

  // Offset the chip register sits behind the read pointer.
  localparam logic [15:0] PTR_REG_BIAS = 16'd16;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 4'd1;

  // Reset values of the configuration registers.
  localparam logic [15:0] MIN_FRAME_RST = 16'd60;
  localparam logic [15:0] MAX_FRAME_RST = 16'd1514;

  // Output word layout.
  localparam int unsigned OFFS_W      = 13;
  localparam int unsigned OUT_BITS    = 91;
  localparam int unsigned OUT_DATA_W  = 96;

  typedef struct packed {
    logic              frame_ok;
    logic [OFFS_W-1:0] header_offset;
    logic [15:0]       payload_len;
    logic [15:0]       first_seg_len;
    logic [15:0]       second_seg_len;
    logic [OFFS_W-1:0] next_offset;
    logic [15:0]       read_ptr_reg;
  } rxrft_result_t;

endpackage

`default_nettype wire

FILE: rtl/rxrft_frame_eval.sv
// Header check, segment split and read pointer advance for one frame header.
`default_nettype none

module rxrft_frame_eval
  import rxrft_pkg::*;
#(
  parameter int unsigned RING_BYTES = 8192
) (
  input  logic [15:0]   hdr_status,
  input  logic [15:0]   rx_size,
  input  logic [15:0]   min_frame,
  input  logic [15:0]   max_frame,
  input  logic [15:0]   read_ptr,
  input  logic [15:0]   ring_pos,
  output rxrft_result_t result,
  output logic [15:0]   read_ptr_nxt,
  output logic [15:0]   ring_pos_nxt
);

  localparam logic [16:0] RING_C = 17'(RING_BYTES);

  // Remainder by the ring size through a short chain of shifted subtracts.
  function automatic logic [15:0] mod_ring(input logic [15:0] x);
    logic [16:0] r;
    r = {1'b0, x};
    for (int k = 6; k >= 0; k--) begin
      if ((RING_BYTES << k) <= 65535) begin
        if (r >= 17'(RING_BYTES << k)) begin
          r = r - 17'(RING_BYTES << k);
        end
      end
    end
    return r[15:0];
  endfunction

  logic        bad;
  logic [15:0] payload;
  logic        wraps;
  logic [16:0] avail;
  logic [16:0] first_w;
  logic [15:0] first_len;
  logic [15:0] second_len;
  logic [17:0] ptr_sum;
  logic [15:0] next_ptr;
  logic [15:0] next_offs;

  // Error flags and size limits; the upper limit is compared at 17 bits.
  assign bad = ((hdr_status & ERR_FLAGS) != 16'd0)
            || (rx_size < min_frame)
            || ({1'b0, rx_size} > ({1'b0, max_frame} + {1'b0, FCS_BYTES}))
            || (rx_size < FCS_BYTES);

  assign payload = rx_size - FCS_BYTES;

  // Split the payload when the frame runs past the ring end.
  assign wraps = ({1'b0, ring_pos} + {1'b0, rx_size}) > RING_C;
  assign avail = RING_C - {1'b0, ring_pos};

  always_comb begin
    first_w    = (avail > {1'b0, FCS_BYTES}) ? (avail - {1'b0, FCS_BYTES}) : 17'd0;
    first_len  = payload;
    second_len = 16'd0;
    if (wraps) begin
      first_len  = (first_w > {1'b0, payload}) ? payload : first_w[15:0];
      second_len = payload - first_len;
    end
  end

  // Advance past header and frame, rounded up to the next dword.
  assign ptr_sum   = {2'b00, read_ptr} + {2'b00, rx_size} + 18'd7;
  assign next_ptr  = ptr_sum[15:0] & DWORD_MASK;
  assign next_offs = mod_ring(next_ptr);

  always_comb begin
    result               = '0;
    result.header_offset = ring_pos[OFFS_W-1:0];
    read_ptr_nxt         = 16'd0;
    ring_pos_nxt         = 16'd0;
    if (!bad) begin
      result.frame_ok       = 1'b1;
      result.payload_len    = payload;
      result.first_seg_len  = first_len;
      result.second_seg_len = second_len;
      result.next_offset    = next_offs[OFFS_W-1:0];
      result.read_ptr_reg   = next_ptr - PTR_REG_BIAS;
      read_ptr_nxt          = next_ptr;
      ring_pos_nxt          = next_offs;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rx_ring_frame_tracker.sv
// Receive ring frame tracker: checks frame headers and tracks the ring read pointer.
//
// The in_ channel carries one frame header per word: status word and size word.
// Each accepted header produces exactly one result word on the out_ channel:
// the accept flag, header offset, payload length, the two segment lengths
// when the payload wraps past the ring end, the next header offset and the
// value for the read pointer register (pointer minus 16).
// The cfg_ channel writes the minimum and maximum frame size registers; it is
// always ready and should only be used while no header is in flight.
// Results are registered in the output register, or in the skid entry while it
// is full. One header per cycle while in_tready is high: the read pointer update
// is a single add, mask and short remainder chain by the ring size, combinational.
// The result side has an output register plus one skid entry, so one more
// header is taken while a result waits; in_tready drops only once both are
// full, and results hold steady until out_tready takes them.
// A rejected header sends the read pointer back to zero.
// Synchronous active-low reset clears the read pointer and the valid flags and
// loads the size limits with 60 and 1514 bytes.
`default_nettype none

module rx_ring_frame_tracker
  import rxrft_pkg::*;
#(
  parameter int unsigned RING_BYTES = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Header input.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // hdr_status[15:0], rx_size[31:16]
  // Result output.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // frame_ok[0], header_offset[13:1], payload_len[29:14], first_seg_len[45:30],
  // second_seg_len[61:46], next_offset[74:62], read_ptr_reg[90:75], zero[95:91]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  logic [15:0]   read_ptr_r;
  logic [15:0]   ring_pos_r;
  logic [15:0]   min_frame_r;
  logic [15:0]   max_frame_r;
  rxrft_result_t out_r;
  logic          out_valid_r;
  rxrft_result_t skid_r;
  logic          skid_valid_r;

  rxrft_result_t result;
  logic [15:0]   read_ptr_nxt;
  logic [15:0]   ring_pos_nxt;
  logic          in_accept;
  logic          out_take;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;
  assign cfg_ready = 1'b1;

  rxrft_frame_eval #(
    .RING_BYTES (RING_BYTES)
  ) u_eval (
    .hdr_status   (in_tdata[15:0]),
    .rx_size      (in_tdata[31:16]),
    .min_frame    (min_frame_r),
    .max_frame    (max_frame_r),
    .read_ptr     (read_ptr_r),
    .ring_pos     (ring_pos_r),
    .result       (result),
    .read_ptr_nxt (read_ptr_nxt),
    .ring_pos_nxt (ring_pos_nxt)
  );

  // Size limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_frame_r <= MIN_FRAME_RST;
      max_frame_r <= MAX_FRAME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_FRAME: min_frame_r <= cfg_data;
        CFG_MAX_FRAME: max_frame_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read pointer and its ring offset advance on every accepted header.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_ptr_r <= 16'd0;
      ring_pos_r <= 16'd0;
    end else if (in_accept) begin
      read_ptr_r <= read_ptr_nxt;
      ring_pos_r <= ring_pos_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= result;
      end
    end else if (in_accept) begin
      skid_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                       out_r.read_ptr_reg,
                       out_r.next_offset,
                       out_r.second_seg_len,
                       out_r.first_seg_len,
                       out_r.payload_len,
                       out_r.header_offset,
                       out_r.frame_ok};

endmodule

`default_nettype wire

FILE: rtl/rxrft_checker.sv
// Port-level checks for the receive ring frame tracker, bound to the top level.
`default_nettype none

module rxrft_checker
  import rxrft_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A result word that waits is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Padding bits above the last field stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
    else $error("nonzero padding in result word");

  // A rejected frame reports zero lengths, next offset and register value.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[90:14] == '0)
    else $error("rejected frame carries nonzero fields");

  // The two segments of an accepted frame add up to the payload.
  a_seg_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      (17'(out_tdata[45:30]) + 17'(out_tdata[61:46])) == 17'(out_tdata[29:14]))
    else $error("segment lengths do not sum to payload");

  // The chip register value of an accepted frame is dword aligned in its low bits.
  a_ptr_reg_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[76:75] == 2'b00)
    else $error("read pointer register value is not dword aligned");

endmodule

bind rx_ring_frame_tracker rxrft_checker u_rxrft_checker (.*);

`default_nettype wire

FILE: test/tb_rx_ring_frame_tracker.sv
// Self-checking testbench for the receive ring frame tracker, with its own header predictor.
`default_nettype none

module tb_rx_ring_frame_tracker;
  import rxrft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING = 8192;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_PER_PHASE = 148;
  localparam int unsigned NUM_PHASES = 6;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} stall_mode_t;

  // One result word, unpacked into fields.
  typedef struct packed {
    logic        ok;
    logic [12:0] hdr_offs;
    logic [15:0] payload;
    logic [15:0] first_seg;
    logic [15:0] second_seg;
    logic [12:0] next_offs;
    logic [15:0] ptr_reg;
  } frame_result_t;

  // One directed header, with an optional hand-written result.
  typedef struct {
    logic [15:0]   status;
    logic [15:0]   size;
    bit            typed;
    frame_result_t res;
  } header_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_FRAME;
  logic [15:0]           cfg_data = '0;

  // Predictor state: read pointer and frame size limits.
  logic [15:0] rd_ptr = '0;
  logic [15:0] min_len = MIN_FRAME_RST;
  logic [15:0] max_len = MAX_FRAME_RST;

  frame_result_t frame_q[$];
  header_row_t   dir_rows[$];
  int unsigned   mismatches = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left = 0;
  stall_mode_t   stall_mode = RX_FREE;
  int unsigned   mode_left = 0;
  int unsigned   pat_cnt = 0;

  // Size limit settings walked by the random phases.
  logic [15:0] phase_min [NUM_PHASES] = '{16'd0, 16'd65535, 16'd0, 16'd64, 16'd4, 16'd60};
  logic [15:0] phase_max [NUM_PHASES] = '{16'd65531, 16'd65531, 16'd0, 16'd1500, 16'd9000,
                                          16'd1514};

  rx_ring_frame_tracker #(
    .RING_BYTES(RING)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Checks one header against the limits and moves the read pointer on.
  function automatic frame_result_t track_frame(input logic [15:0] status,
                                                input logic [15:0] size);
    frame_result_t r;
    int unsigned   offs;
    int unsigned   size_u;
    int unsigned   payload;
    int unsigned   first;
    int unsigned   avail;
    int unsigned   nxt;
    logic          rejected;
    r = '0;
    size_u = 32'(size);
    offs = rd_ptr % RING;
    r.hdr_offs = offs[12:0];
    rejected = ((status & ERR_FLAGS) != 16'h0) || (size < min_len) ||
               (size_u > max_len + 32'd4) || (size < FCS_BYTES);
    if (rejected) begin
      rd_ptr = '0;
    end else begin
      payload = size_u - FCS_BYTES;
      first = payload;
      // Payload runs past the ring end; a header in the last dword leaves no first segment.
      if (offs + size_u > RING) begin
        avail = RING - offs;
        first = (avail > FCS_BYTES) ? avail - FCS_BYTES : 32'd0;
        if (first > payload) first = payload;
      end
      nxt = (rd_ptr + size_u + FCS_BYTES + 32'd3) & {16'h0, DWORD_MASK};
      rd_ptr = nxt[15:0];
      r.ok = 1'b1;
      r.payload = payload[15:0];
      r.first_seg = first[15:0];
      r.second_seg = payload[15:0] - first[15:0];
      r.next_offs = 13'(nxt % RING);
      r.ptr_reg = nxt[15:0] - PTR_REG_BIAS;
    end
    return r;
  endfunction

  task automatic add_row(input logic [15:0] status, input logic [15:0] size, input bit typed,
                         input logic ok, input logic [12:0] hdr, input logic [15:0] pl,
                         input logic [15:0] f, input logic [15:0] s, input logic [12:0] nx,
                         input logic [15:0] ptr);
    header_row_t row;
    row.status = status;
    row.size = size;
    row.typed = typed;
    row.res = '{ok, hdr, pl, f, s, nx, ptr};
    dir_rows.push_back(row);
  endtask

  // Offers one header word and records its expected result once it is taken.
  task automatic push_header(input logic [15:0] status, input logic [15:0] size,
                             input bit typed, input frame_result_t given);
    frame_result_t pred;
    in_tvalid <= 1'b1;
    in_tdata <= {size, status};
    do @(posedge clk); while (!in_tready);
    pred = track_frame(status, size);
    frame_q.push_back(typed ? given : pred);
  endtask

  // Sender bursts: after a burst, an optional gap with valid low.
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(99) < 35) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Lets every outstanding result come back before anything else happens.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_FRAME: min_len = value;
      CFG_MAX_FRAME: max_len = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly good headers with sizes inside the limits, some errors and boundary sizes.
  task automatic random_header(output logic [15:0] status, output logic [15:0] size);
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    int unsigned sz_u;
    pick = $urandom_range(99);
    lo = (min_len < FCS_BYTES) ? 32'(FCS_BYTES) : 32'(min_len);
    hi = max_len + 32'd4;
    if (hi > 65535) hi = 65535;
    status = 16'($urandom) & ~ERR_FLAGS;
    if (pick < 12) status[$urandom_range(5, 1)] = 1'b1;
    if ((pick >= 12 && pick < 25) || lo > hi) begin
      sz_u = $urandom;
    end else if (pick < 33) begin
      case ($urandom_range(3))
        0: sz_u = lo - 1;
        1: sz_u = lo;
        2: sz_u = hi;
        default: sz_u = hi + 1;
      endcase
    end else if (pick < 75) begin
      sz_u = $urandom_range(lo + ((hi - lo < 1500) ? hi - lo : 1500), lo);
    end else begin
      sz_u = $urandom_range(hi, lo);
    end
    size = sz_u[15:0];
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Result monitor: compares each taken word with the oldest expectation.
  always @(posedge clk) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok = out_tdata[0];
      got.hdr_offs = out_tdata[13:1];
      got.payload = out_tdata[29:14];
      got.first_seg = out_tdata[45:30];
      got.second_seg = out_tdata[61:46];
      got.next_offs = out_tdata[74:62];
      got.ptr_reg = out_tdata[90:75];
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result word with nothing expected", $realtime);
      end else begin
        want = frame_q.pop_front();
        check_field("frame_ok", want.ok, got.ok);
        check_field("header_offset", want.hdr_offs, got.hdr_offs);
        check_field("payload_len", want.payload, got.payload);
        check_field("first_seg_len", want.first_seg, got.first_seg);
        check_field("second_seg_len", want.second_seg, got.second_seg);
        check_field("next_offset", want.next_offs, got.next_offs);
        check_field("read_ptr_reg", want.ptr_reg, got.ptr_reg);
      end
    end
  end

  // Receiver backpressure: free-running, random and periodic stretches.
  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 1;
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(2));
      mode_left <= $urandom_range(300, 20);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(99) < 60);
      default:   out_tready <= ((pat_cnt % 5) < 2);
    endcase
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] st;
    logic [15:0] sz;

    // Directed headers under the reset limits of 60 and 1514 bytes.
    add_row(16'h0000, 16'd60, 1, 1'b1, 13'd0, 16'd56, 16'd56, 16'd0, 13'd64, 16'd48);
    add_row(ERR_SYMBOL, 16'd100, 1, 1'b0, 13'd64, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(ERR_RUNT, 16'd100, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(ERR_LONG, 16'd100, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(ERR_CRC, 16'd100, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(ERR_ALIGN, 16'd100, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(16'h0000, 16'd0, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(16'h0000, 16'd3, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(16'h0000, 16'd59, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(16'h0000, 16'd65535, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(16'h0000, 16'd1519, 1, 1'b0, 13'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
    add_row(16'hFFC1, 16'd1518, 1, 1'b1, 13'd0, 16'd1514, 16'd1514, 16'd0, 13'd1524, 16'd1508);
    // Walk the pointer up to the last dword of the ring, then straddle the ring end.
    repeat (4) add_row(16'h0000, 16'd1516, 0, '0, '0, '0, '0, '0, '0, '0);
    add_row(16'h0000, 16'd580, 0, '0, '0, '0, '0, '0, '0, '0);
    add_row(16'h0000, 16'd100, 0, '0, '0, '0, '0, '0, '0, '0);
    add_row(16'h0000, 16'd1518, 0, '0, '0, '0, '0, '0, '0, '0);
    add_row(16'hFFFF, 16'd60, 0, '0, '0, '0, '0, '0, '0, '0);
    add_row(16'h0000, 16'd1000, 0, '0, '0, '0, '0, '0, '0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      push_header(dir_rows[i].status, dir_rows[i].size, dir_rows[i].typed, dir_rows[i].res);
      pace();
    end

    // Random headers under the reset limits, then under each further setting.
    for (int p = 0; p <= NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        write_limit(CFG_MIN_FRAME, phase_min[p - 1]);
        write_limit(CFG_MAX_FRAME, phase_max[p - 1]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_header(st, sz);
        push_header(st, sz, 1'b0, '0);
        pace();
      end
    end

    drain();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
